// ----- sv/fik_pkg.sv -----
// Shared constants and types for the planar FABRIK IK solver.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fik_pkg;
    localparam int MAX_BONES = 8;
    localparam int JOINTS = MAX_BONES + 1;
    localparam int IDX_W = 4;
    localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_BONES);
    localparam logic [31:0] ONE_UNIT = 32'h0001_0000;

    typedef enum logic [1:0] {
        REG_BONE_COUNT = 2'd0,
        REG_BONE_LENGTH = 2'd1,
        REG_ITER_COUNT = 2'd2
    } reg_idx_t;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_SOLVE = 1'b1
    } op_t;

    // request to the bone placement unit
    typedef struct packed {
        logic signed [32:0] ax;
        logic signed [32:0] ay;
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        logic [11:0] blen;
    } place_req_t;

    typedef struct packed {
        logic signed [31:0] nx;
        logic signed [31:0] ny;
    } place_rsp_t;
endpackage
`default_nettype wire

// ----- sv/fik_place.sv -----
// Bone placement unit: normalize, isqrt, two long divides, add and saturate.
// Depends on fik_pkg. Iterative, one bit per cycle; a zero direction is answered straight from idle.
`timescale 1ns / 1ps
`default_nettype none
module fik_place
    import fik_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire place_req_t req,
    output logic            done,
    output place_rsp_t      rsp
);
    typedef enum logic [3:0] {
        S_IDLE, S_NORM, S_SQX, S_SQY, S_SQRT, S_MULX, S_DIVX, S_MULY, S_DIVY, S_FIN
    } state_t;

    state_t state_reg;
    logic signed [32:0] ax_reg, ay_reg;
    logic sx_reg, sy_reg;
    logic [33:0] ux_reg, uy_reg;
    logic [11:0] blen_reg;
    logic [63:0] sq_reg;
    logic [63:0] rem_reg;   // isqrt remainder
    logic [31:0] res_reg;   // isqrt root
    logic [5:0] cnt_reg;
    logic [63:0] quo_reg;
    logic [64:0] drem_reg;
    logic [31:0] ox_reg;

    // 32x32 product reused for squares and for u*blen
    logic [31:0] ma, mb;
    logic [63:0] prod;
    always_comb
    begin
        ma = ux_reg[31:0];
        mb = ux_reg[31:0];
        case (state_reg)
            S_SQY:   begin ma = uy_reg[31:0]; mb = uy_reg[31:0]; end
            S_MULX:  begin ma = ux_reg[31:0]; mb = {4'd0, blen_reg, 16'd0}; end
            S_MULY:  begin ma = uy_reg[31:0]; mb = {4'd0, blen_reg, 16'd0}; end
            default: ;
        endcase
        prod = ma * mb;
    end

    logic [33:0] mag;
    assign mag = (ux_reg > uy_reg) ? ux_reg : uy_reg;

    // isqrt step: bit pair position = cnt
    logic [63:0] bitv;
    assign bitv = 64'd1 << {cnt_reg, 1'b0};

    logic [64:0] dshift;
    logic [64:0] dsub;
    assign dshift = {drem_reg[63:0], quo_reg[63]};
    assign dsub = dshift - {33'd0, res_reg};

    logic signed [33:0] sum;
    logic signed [33:0] off;
    always_comb
    begin
        off = sy_reg ? -$signed({2'b00, quo_reg[31:0]}) : $signed({2'b00, quo_reg[31:0]});
        if (state_reg == S_FIN)
            sum = 34'(ay_reg) + off;
        else
            sum = 34'(ax_reg) + (sx_reg ? -$signed({2'b00, quo_reg[31:0]})
                                        : $signed({2'b00, quo_reg[31:0]}));
    end

    function automatic logic signed [31:0] sat(input logic signed [33:0] v);
        if (v > 34'sh7FFF_FFFF)
            return 32'h7FFF_FFFF;
        else if (v < -34'sh8000_0000)
            return 32'h8000_0000;
        else
            return v[31:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        ax_reg <= req.ax;
                        ay_reg <= req.ay;
                        sx_reg <= req.dx[33];
                        sy_reg <= req.dy[33];
                        ux_reg <= req.dx[33] ? 34'(-req.dx) : 34'(req.dx);
                        uy_reg <= req.dy[33] ? 34'(-req.dy) : 34'(req.dy);
                        blen_reg <= req.blen;
                        if (req.dx == '0 && req.dy == '0)
                        begin
                            rsp.nx <= req.ax[31:0];
                            rsp.ny <= req.ay[31:0];
                            done <= 1'b1;
                        end
                        else
                            state_reg <= S_NORM;
                    end
                end
                S_NORM:
                begin
                    if (mag >= 34'h8000_0000)
                    begin
                        ux_reg <= ux_reg >> 1;
                        uy_reg <= uy_reg >> 1;
                    end
                    else if (mag < 34'h4000_0000)
                    begin
                        ux_reg <= ux_reg << 1;
                        uy_reg <= uy_reg << 1;
                    end
                    else
                        state_reg <= S_SQX;
                end
                S_SQX:
                begin
                    sq_reg <= prod;
                    state_reg <= S_SQY;
                end
                S_SQY:
                begin
                    rem_reg <= sq_reg + prod;
                    res_reg <= '0;
                    cnt_reg <= 6'd31;
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    // (res + 2^k)^2 - res^2 = res * 2^(k+1) + 4^k
                    if (rem_reg >= (({32'd0, res_reg} << (cnt_reg + 6'd1)) + bitv))
                    begin
                        rem_reg <= rem_reg - (({32'd0, res_reg} << (cnt_reg + 6'd1))
                                   + bitv);
                        res_reg <= res_reg | (32'd1 << cnt_reg[4:0]);
                    end
                    if (cnt_reg == 6'd0)
                        state_reg <= S_MULX;
                    else
                        cnt_reg <= cnt_reg - 6'd1;
                end
                S_MULX, S_MULY:
                begin
                    quo_reg <= prod + {33'd0, res_reg[31:1]};
                    drem_reg <= '0;
                    cnt_reg <= 6'd63;
                    state_reg <= (state_reg == S_MULX) ? S_DIVX : S_DIVY;
                end
                S_DIVX, S_DIVY:
                begin
                    if (!dsub[64])
                    begin
                        drem_reg <= dsub;
                        quo_reg <= {quo_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg <= dshift;
                        quo_reg <= {quo_reg[62:0], 1'b0};
                    end
                    if (cnt_reg == 6'd0)
                    begin
                        if (state_reg == S_DIVX)
                        begin
                            state_reg <= S_MULY;
                            ox_reg <= !dsub[64] ? {quo_reg[30:0], 1'b1}
                                                : {quo_reg[30:0], 1'b0};
                        end
                        else
                            state_reg <= S_FIN;
                    end
                    else
                        cnt_reg <= cnt_reg - 6'd1;
                end
                S_FIN:
                begin
                    rsp.ny <= sat(sum);
                    rsp.nx <= sat(34'(ax_reg) + (sx_reg ? -$signed({2'b00, ox_reg})
                                                         : $signed({2'b00, ox_reg})));
                    done <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- sv/fabrik_planar_ik_solver.sv -----
// Top level of the planar FABRIK IK solver: joint memories and pass sequencer.
// Depends on fik_pkg and fik_place.
//
// channel | dir | handshake      | contents
// s_axis  | in  | tvalid/tready  | tdata: joint_index[3:0], coord_x[35:4], coord_y[67:36]; tuser: op
// m_axis  | out | tvalid/tready  | tdata: out_index[3:0], out_x[35:4], out_y[67:36]; tlast: last
// cfg     | in  | wr_en          | wr_index, wr_data[11:0]
//
// A load is written as it is accepted, with s_axis still ready. A solve takes iterations *
// (2 * bones - 1) placements, each through the normalize shifts, the bit-serial sqrt and the
// two long divides (a zero direction skips them), then S_OUTRD, S_OUTW and S_OUT per joint.
// Reset clears control and the config registers to their defaults; memories and datapath registers hold no reset.
// The output register stalls the readout while m_axis_tready is low.
`timescale 1ns / 1ps
`default_nettype none
module fabrik_planar_ik_solver
    import fik_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,   // joint_index, coord_x, coord_y
    input  wire logic        s_axis_tuser,   // op
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,   // out_index, out_x, out_y
    output logic             m_axis_tlast,   // last
    input  wire logic        wr_en,
    input  wire logic [1:0]  wr_index,
    input  wire logic [11:0] wr_data
);
    typedef enum logic [3:0] {
        S_IDLE, S_PIN, S_RD0, S_RD1, S_CALC, S_WAIT, S_OUTRD, S_OUTW, S_OUT
    } state_t;

    state_t state_reg;
    logic [3:0] bone_count_reg, iter_reg;
    logic [11:0] blen_reg;
    logic signed [31:0] mem_x [JOINTS];
    logic signed [31:0] mem_y [JOINTS];
    logic signed [31:0] rdx_reg, rdy_reg;
    logic signed [31:0] ax_reg, ay_reg;   // anchor joint
    logic signed [31:0] tx_reg, ty_reg;   // target
    logic [3:0] n_reg, it_reg, i_reg;
    logic bwd_reg, first_reg;
    logic [IDX_W-1:0] raddr;
    logic [IDX_W-1:0] waddr;
    logic we;
    logic signed [31:0] wx, wy;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_x[waddr] <= wx;
            mem_y[waddr] <= wy;
        end
        rdx_reg <= mem_x[raddr];
        rdy_reg <= mem_y[raddr];
    end

    logic start;
    place_req_t req;
    logic pdone;
    place_rsp_t prsp;
    fik_place u_place (.clk(clk), .rst_n(rst_n), .start(start), .req(req),
                       .done(pdone), .rsp(prsp));

    logic [3:0] n_eff;
    assign n_eff = (bone_count_reg == 4'd0) ? 4'd1 :
                   (bone_count_reg > MAX_IDX) ? MAX_IDX : bone_count_reg;

    logic s_fire;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_fire = s_axis_tvalid && s_axis_tready;

    // target joint index being placed, anchor index
    logic [3:0] tgt;
    assign tgt = bwd_reg ? i_reg - 4'd1 : i_reg + 4'd1;

    always_comb
    begin
        we = 1'b0;
        waddr = s_axis_tdata[3:0];
        wx = s_axis_tdata[35:4];
        wy = s_axis_tdata[67:36];
        raddr = i_reg;
        case (state_reg)
            S_IDLE: we = s_fire && (s_axis_tuser == OP_LOAD) && (s_axis_tdata[3:0] <= MAX_IDX);
            S_PIN:
            begin
                // no pin after the last forward pass
                we = (it_reg != 4'd0) || first_reg;
                waddr = n_reg;
                wx = tx_reg;
                wy = ty_reg;
            end
            S_RD0: raddr = i_reg;
            S_RD1: raddr = tgt;
            S_WAIT:
            begin
                we = pdone;
                waddr = tgt;
                wx = prsp.nx;
                wy = prsp.ny;
            end
            default: ;
        endcase
        req.ax = 33'(ax_reg);
        req.ay = 33'(ay_reg);
        req.dx = 34'(rdx_reg) + ((bwd_reg && first_reg) ? 34'(ONE_UNIT) : 34'd0) - 34'(ax_reg);
        req.dy = 34'(rdy_reg) - 34'(ay_reg);
        req.blen = blen_reg;
        start = (state_reg == S_CALC);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            bone_count_reg <= 4'd2;
            blen_reg <= 12'd100;
            iter_reg <= 4'd5;
            m_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                case (reg_idx_t'(wr_index))
                    REG_BONE_COUNT:  bone_count_reg <= wr_data[3:0];
                    REG_BONE_LENGTH: blen_reg <= wr_data;
                    REG_ITER_COUNT:  iter_reg <= wr_data[3:0];
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_fire && s_axis_tuser == OP_SOLVE)
                    begin
                        n_reg <= n_eff;
                        tx_reg <= s_axis_tdata[35:4];
                        ty_reg <= s_axis_tdata[67:36];
                        it_reg <= iter_reg;
                        first_reg <= 1'b1;
                        state_reg <= S_PIN;
                    end
                end
                S_PIN:
                begin
                    if (it_reg == 4'd0)
                    begin
                        i_reg <= 4'd0;
                        state_reg <= S_OUTRD;
                    end
                    else if (n_reg > 4'd1)
                    begin
                        bwd_reg <= 1'b1;
                        i_reg <= n_reg;
                        state_reg <= S_RD0;
                    end
                    else
                    begin
                        bwd_reg <= 1'b0;
                        i_reg <= 4'd0;
                        state_reg <= S_RD0;
                    end
                end
                S_RD0: state_reg <= S_RD1;
                S_RD1:
                begin
                    ax_reg <= rdx_reg;
                    ay_reg <= rdy_reg;
                    state_reg <= S_CALC;
                end
                S_CALC: state_reg <= S_WAIT;
                S_WAIT:
                begin
                    if (pdone)
                    begin
                        state_reg <= S_RD0;
                        if (bwd_reg)
                        begin
                            if (i_reg == 4'd2)
                            begin
                                bwd_reg <= 1'b0;
                                i_reg <= 4'd0;
                            end
                            else
                                i_reg <= i_reg - 4'd1;
                        end
                        else if (i_reg + 4'd1 == n_reg)
                        begin
                            first_reg <= 1'b0;
                            it_reg <= it_reg - 4'd1;
                            state_reg <= S_PIN;
                        end
                        else
                            i_reg <= i_reg + 4'd1;
                    end
                end
                S_OUTRD: state_reg <= S_OUTW;
                S_OUTW:
                begin
                    m_axis_tvalid <= 1'b1;
                    m_axis_tdata <= {4'd0, rdy_reg, rdx_reg, i_reg};
                    m_axis_tlast <= (i_reg == n_reg);
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (m_axis_tready)
                    begin
                        m_axis_tvalid <= 1'b0;
                        if (i_reg == n_reg)
                            state_reg <= S_IDLE;
                        else
                        begin
                            i_reg <= i_reg + 4'd1;
                            state_reg <= S_OUTRD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
